FILE: rtl/dab_pkg.sv
package dab_pkg;

  localparam int NUM_BLOCKS = 64;
  localparam int BLK_W      = $clog2(NUM_BLOCKS);
  localparam int LINK_W     = BLK_W + 1;
  localparam int ID_W       = 8;
  localparam int LEN_W      = 7;
  localparam int OP_W       = 2;
  localparam int ST_W       = 2;
  localparam int FB_W       = 7;
  localparam int IN_W       = OP_W + ID_W + LEN_W + FB_W;
  localparam int OUT_W      = ST_W + FB_W + LEN_W;

  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(NUM_BLOCKS);
  localparam logic [FB_W-1:0]   FB_NONE   = '1;

  // operation codes
  localparam logic [OP_W-1:0] OP_CONTIG = 2'd0;
  localparam logic [OP_W-1:0] OP_LINKED = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_NOSPACE  = 2'd1;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd2;

  typedef enum logic [1:0] {
    RES_NOSPACE,
    RES_NOTFOUND,
    RES_ALLOC,
    RES_FREED
  } res_kind_t;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_CHECK   = 10'b00_0000_0010,
    S_C_SCAN  = 10'b00_0000_0100,
    S_C_FILL  = 10'b00_0000_1000,
    S_L_COUNT = 10'b00_0001_0000,
    S_L_CHECK = 10'b00_0010_0000,
    S_L_FILL  = 10'b00_0100_0000,
    S_L_TAIL  = 10'b00_1000_0000,
    S_R_READ  = 10'b01_0000_0000,
    S_R_STEP  = 10'b10_0000_0000
  } state_t;

  typedef struct packed {
    logic      load_req;
    logic      clr_work;
    logic      c_scan_step;
    logic      c_fill_step;
    logic      l_count_step;
    logic      l_fill_step;
    logic      l_tail;
    logic      r_step;
    logic      push;
    res_kind_t kind;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            len_bad;
    logic            start_bad;
    logic            c_hit;
    logic            scan_last;
    logic            fill_last;
    logic            l_short;
    logic            l_hit;
    logic            walk_done;
    logic            out_free;
  } sts_t;

endpackage

FILE: rtl/dab_ram.sv
module dab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/dab_datapath.sv
module dab_datapath import dab_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,
  input  cmd_t             cmd,
  output sts_t             sts
);

  logic [OP_W-1:0]       req_op;
  logic [ID_W-1:0]       req_id;
  logic [LEN_W-1:0]      req_len;
  logic [FB_W-1:0]       req_start;

  logic [BLK_W-1:0]      idx;
  logic [BLK_W-1:0]      first;
  logic [BLK_W-1:0]      prev;
  logic [LEN_W-1:0]      run;
  logic [LEN_W-1:0]      cnt;
  logic [LEN_W-1:0]      steps;
  logic [LINK_W-1:0]     cur;
  logic [NUM_BLOCKS-1:0] used;

  logic                  blk_free;
  logic [LEN_W-1:0]      run_inc;
  logic [LEN_W-1:0]      cnt_inc;
  logic [LEN_W-1:0]      steps_inc;
  logic [LEN_W-1:0]      c_run_next;
  logic [BLK_W-1:0]      c_first_next;
  logic                  c_hit;
  logic                  cur_used;
  logic [LINK_W-1:0]     link_rdata;
  logic [LINK_W-1:0]     walk_link;

  logic                  link_we;
  logic [BLK_W-1:0]      link_waddr;
  logic [LINK_W-1:0]     link_wdata;
  logic                  owner_we;

  assign blk_free     = !used[idx];
  assign run_inc      = run + 1'b1;
  assign cnt_inc      = cnt + 1'b1;
  assign steps_inc    = steps + 1'b1;
  assign c_run_next   = blk_free ? run_inc : '0;
  assign c_first_next = (blk_free && run == '0) ? idx : first;
  assign c_hit        = blk_free && (run_inc == req_len);

  // a free block always reads as having no successor
  assign cur_used  = used[cur[BLK_W-1:0]];
  assign walk_link = cur_used ? link_rdata : LINK_NONE;

  always_comb begin
    link_we    = 1'b0;
    link_waddr = idx;
    link_wdata = LINK_NONE;
    if (cmd.c_fill_step) begin
      link_we    = 1'b1;
      link_waddr = idx;
      link_wdata = (cnt_inc == req_len) ? LINK_NONE : LINK_W'(idx) + 1'b1;
    end else if (cmd.l_fill_step && blk_free && cnt != '0) begin
      link_we    = 1'b1;
      link_waddr = prev;
      link_wdata = LINK_W'(idx);
    end else if (cmd.l_tail) begin
      link_we    = 1'b1;
      link_waddr = prev;
      link_wdata = LINK_NONE;
    end
  end

  assign owner_we = cmd.c_fill_step || (cmd.l_fill_step && blk_free);

  dab_ram #(.WIDTH(LINK_W), .DEPTH(NUM_BLOCKS)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (cur[BLK_W-1:0]),
    .rdata (link_rdata)
  );

  dab_ram #(.WIDTH(ID_W), .DEPTH(NUM_BLOCKS)) u_owner_ram (
    .clk   (clk),
    .we    (owner_we),
    .waddr (idx),
    .wdata (req_id),
    .raddr (idx),
    .rdata ()
  );

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_op    <= s_tdata[OP_W-1:0];
      req_id    <= s_tdata[OP_W +: ID_W];
      req_len   <= s_tdata[OP_W+ID_W +: LEN_W];
      req_start <= s_tdata[OP_W+ID_W+LEN_W +: FB_W];
    end
    if (cmd.clr_work) begin
      idx   <= '0;
      run   <= '0;
      cnt   <= '0;
      steps <= '0;
      cur   <= LINK_W'(req_start[BLK_W-1:0]);
    end
    if (cmd.c_scan_step) begin
      run   <= c_run_next;
      first <= c_first_next;
      idx   <= c_hit ? c_first_next : idx + 1'b1;
    end
    if (cmd.c_fill_step) begin
      idx <= idx + 1'b1;
      cnt <= cnt_inc;
    end
    if (cmd.l_count_step) begin
      idx <= idx + 1'b1;
      cnt <= cnt + LEN_W'(blk_free);
    end
    if (cmd.l_fill_step) begin
      idx <= idx + 1'b1;
      if (blk_free) begin
        prev <= idx;
        cnt  <= cnt_inc;
        if (cnt == '0) begin
          first <= idx;
        end
      end
    end
    if (cmd.r_step) begin
      if (cur_used) begin
        cnt <= cnt_inc;
      end
      cur   <= walk_link;
      steps <= steps_inc;
    end
  end

  // occupancy bits
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      if (cmd.c_fill_step || (cmd.l_fill_step && blk_free)) begin
        used[idx] <= 1'b1;
      end
      if (cmd.r_step) begin
        used[cur[BLK_W-1:0]] <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      case (cmd.kind)
        RES_ALLOC:    m_tdata <= {req_len, FB_W'(first), ST_OK};
        RES_FREED:    m_tdata <= {cnt, FB_NONE, ST_OK};
        RES_NOTFOUND: m_tdata <= {LEN_W'(0), FB_NONE, ST_NOTFOUND};
        default:      m_tdata <= {LEN_W'(0), FB_NONE, ST_NOSPACE};
      endcase
    end
  end

  always_comb begin
    sts.op        = req_op;
    sts.len_bad   = (req_len == '0) || (req_len > LEN_W'(NUM_BLOCKS));
    sts.start_bad = req_start[FB_W-1] || (req_start >= FB_W'(NUM_BLOCKS));
    sts.c_hit     = c_hit;
    sts.scan_last = (idx == BLK_W'(NUM_BLOCKS - 1));
    sts.fill_last = (cnt_inc == req_len);
    sts.l_short   = (cnt < req_len);
    sts.l_hit     = blk_free && (cnt_inc == req_len);
    sts.walk_done = (walk_link >= LINK_NONE) || (steps_inc == LEN_W'(NUM_BLOCKS));
    sts.out_free  = !m_tvalid || m_tready;
  end

endmodule

FILE: rtl/dab_ctrl.sv
module dab_ctrl import dab_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t    state;
  state_t    state_next;
  res_kind_t kind;
  res_kind_t kind_next;
  logic      in_result;
  logic      in_result_next;

  assign s_tready = (state == S_IDLE) && !in_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_result <= 1'b0;
    end else begin
      state     <= state_next;
      in_result <= in_result_next;
    end
  end

  always_ff @(posedge clk) begin
    kind <= kind_next;
  end

  always_comb begin
    state_next     = state;
    kind_next      = kind;
    in_result_next = in_result;
    cmd            = '0;
    cmd.kind       = kind;

    // finished result waits here for the output register
    if (in_result) begin
      if (sts.out_free) begin
        cmd.push       = 1'b1;
        in_result_next = 1'b0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd.load_req = 1'b1;
            state_next   = S_CHECK;
          end
        end
        S_CHECK: begin
          cmd.clr_work = 1'b1;
          state_next   = S_IDLE;
          if (sts.op == OP_CONTIG && !sts.len_bad) begin
            state_next = S_C_SCAN;
          end else if (sts.op == OP_LINKED && !sts.len_bad) begin
            state_next = S_L_COUNT;
          end else if (sts.op == OP_REMOVE && !sts.start_bad) begin
            state_next = S_R_READ;
          end else begin
            kind_next      = (sts.op == OP_REMOVE) ? RES_NOTFOUND : RES_NOSPACE;
            in_result_next = 1'b1;
          end
        end
        S_C_SCAN: begin
          cmd.c_scan_step = 1'b1;
          if (sts.c_hit) begin
            state_next = S_C_FILL;
          end else if (sts.scan_last) begin
            state_next     = S_IDLE;
            kind_next      = RES_NOSPACE;
            in_result_next = 1'b1;
          end
        end
        S_C_FILL: begin
          cmd.c_fill_step = 1'b1;
          if (sts.fill_last) begin
            state_next     = S_IDLE;
            kind_next      = RES_ALLOC;
            in_result_next = 1'b1;
          end
        end
        S_L_COUNT: begin
          cmd.l_count_step = 1'b1;
          if (sts.scan_last) begin
            state_next = S_L_CHECK;
          end
        end
        S_L_CHECK: begin
          if (sts.l_short) begin
            state_next     = S_IDLE;
            kind_next      = RES_NOSPACE;
            in_result_next = 1'b1;
          end else begin
            cmd.clr_work = 1'b1;
            state_next   = S_L_FILL;
          end
        end
        S_L_FILL: begin
          cmd.l_fill_step = 1'b1;
          if (sts.l_hit) begin
            state_next = S_L_TAIL;
          end
        end
        S_L_TAIL: begin
          cmd.l_tail     = 1'b1;
          state_next     = S_IDLE;
          kind_next      = RES_ALLOC;
          in_result_next = 1'b1;
        end
        S_R_READ: begin
          state_next = S_R_STEP;
        end
        S_R_STEP: begin
          cmd.r_step = 1'b1;
          if (sts.walk_done) begin
            state_next     = S_IDLE;
            kind_next      = RES_FREED;
            in_result_next = 1'b1;
          end else begin
            state_next = S_R_READ;
          end
        end
        default: begin
          state_next = S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/disk_block_allocator.sv
// contiguous request: first-fit scan, then fill;
// linked request: free count pass, then claim pass and tail link;
// remove: walks the chain, with a read state before each step for the registered read of the link memory
// one request at a time; the next is taken once the result sits in the output register
// reset (rst, synchronous) frees every block at once, no clearing pass is needed
module disk_block_allocator import dab_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  // request channel
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // op[1:0], file_id[9:2], length[16:10], start_block[23:17]
  // result channel
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // status[1:0], first_block[8:2], blocks_changed[15:9]
);

  // command and status between sequencer and table datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: decodes the request and steps the scan, fill and walk loops
  dab_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: occupancy bits, link and owner memories, loop counters, result register
  dab_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

FILE: tb/disk_block_allocator_tb.sv
`timescale 1ns / 100ps

module disk_block_allocator_tb import dab_pkg::*; ();

  // op code 3 has no name in the package, it must be rejected
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_REQUESTS = 600;
  // longest request is a full remove walk or linked pass plus both gaps
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 150;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [FB_W-1:0]  first_block;
    logic [LEN_W-1:0] changed;
  } alloc_result_t;

  // shadow copy of the block table, predicts each request's result
  class block_table_tracker;
    bit                used  [NUM_BLOCKS];
    logic [ID_W-1:0]   owner [NUM_BLOCKS];
    logic [LINK_W-1:0] link  [NUM_BLOCKS];
    alloc_result_t     awaited_results[$];
    logic [FB_W-1:0]   file_heads[$];   // first blocks of files handed out
    int                errors;
    int                checked;
    int                status_tally[4];

    function new();
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        used[i]  = 1'b0;
        owner[i] = '0;
        link[i]  = LINK_NONE;
      end
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                               logic [LEN_W-1:0] len, logic [FB_W-1:0] start);
      alloc_result_t r;
      int ln, run, first, freecnt, taken, prev, cur, nxt, steps, freed;
      r = '{ST_NOSPACE, FB_NONE, '0};
      ln = int'(len);
      case (op)
        OP_CONTIG, OP_LINKED: begin
          if (ln != 0 && ln <= NUM_BLOCKS) begin
            if (op == OP_CONTIG) begin
              // first fit: lowest run of ln free blocks, linked in order
              run = 0;
              first = -1;
              for (int i = 0; i < NUM_BLOCKS && first < 0; i++) begin
                if (!used[i]) begin
                  run++;
                  if (run == ln) first = i - ln + 1;
                end else begin
                  run = 0;
                end
              end
              if (first >= 0) begin
                for (int i = first; i < first + ln; i++) begin
                  used[i]  = 1'b1;
                  owner[i] = id;
                  link[i]  = (i + 1 < first + ln) ? LINK_W'(i + 1) : LINK_NONE;
                end
                r = '{ST_OK, FB_W'(first), len};
              end
            end else begin
              // lowest free blocks chained, nothing changes if too few
              freecnt = 0;
              for (int i = 0; i < NUM_BLOCKS; i++)
                if (!used[i]) freecnt++;
              if (freecnt >= ln) begin
                taken = 0;
                prev = 0;
                first = 0;
                for (int i = 0; i < NUM_BLOCKS && taken < ln; i++) begin
                  if (!used[i]) begin
                    used[i]  = 1'b1;
                    owner[i] = id;
                    link[i]  = LINK_NONE;
                    if (taken == 0) first = i;
                    else link[prev] = LINK_W'(i);
                    prev = i;
                    taken++;
                  end
                end
                r = '{ST_OK, FB_W'(first), len};
              end
            end
            if (r.status == ST_OK) file_heads.push_back(r.first_block);
          end
        end
        OP_REMOVE: begin
          if (start[FB_W-1]) begin
            r = '{ST_NOTFOUND, FB_NONE, '0};
          end else begin
            // walk the chain, free blocks count only if they were in use
            cur = int'(start);
            steps = 0;
            freed = 0;
            while (cur < NUM_BLOCKS && steps < NUM_BLOCKS) begin
              nxt = int'(link[cur]);
              if (used[cur]) freed++;
              used[cur]  = 1'b0;
              owner[cur] = '0;
              link[cur]  = LINK_NONE;
              cur = nxt;
              steps++;
            end
            r = '{ST_OK, FB_NONE, LEN_W'(freed)};
          end
        end
        default: ;
      endcase
      awaited_results.push_back(r);
    endfunction

    function void check_result(logic [OUT_W-1:0] data);
      alloc_result_t got, want;
      // status sits in the lowest bits of the result word
      got.status      = data[ST_W-1:0];
      got.first_block = data[ST_W +: FB_W];
      got.changed     = data[ST_W+FB_W +: LEN_W];
      if (awaited_results.size() == 0) begin
        $display("%0t: result with no request pending: status %0d first %0d count %0d",
                 $time, got.status, $signed(got.first_block), got.changed);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      checked++;
      status_tally[got.status]++;
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.first_block !== want.first_block) begin
        $display("%0t: first_block expected %0d got %0d", $time,
                 $signed(want.first_block), $signed(got.first_block));
        errors++;
      end
      if (got.changed !== want.changed) begin
        $display("%0t: blocks_changed expected %0d got %0d", $time, want.changed,
                 got.changed);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  block_table_tracker tracker = new();
  bit no_idle = 1'b0;   // both sides run without gaps while set
  int idle_cycles = 0;

  disk_block_allocator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 13);
  endfunction

  // one request: optional gap, then hold valid until the handshake
  task automatic send_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                              input logic [LEN_W-1:0] len, input logic [FB_W-1:0] start);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {start, len, id, op};
    do @(posedge clk); while (!s_tready);
    tracker.note_request(op, id, len, start);
  endtask

  // result side: random stall before each result, sometimes none
  initial begin
    int stall;
    wait (!rst);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_result(m_tdata);
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int pick, lsel, idx;
    logic [OP_W-1:0]  op;
    logic [ID_W-1:0]  id;
    logic [LEN_W-1:0] len;
    logic [FB_W-1:0]  start;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: rejected op, bad lengths, bad starts, empty disk
    send_request(OP_UNUSED, 8'd0, 7'd0, 7'h7F);
    send_request(OP_CONTIG, 8'd5, 7'd0, 7'd0);
    send_request(OP_LINKED, 8'd5, 7'd0, 7'd0);
    send_request(OP_CONTIG, 8'd6, 7'd65, 7'd0);
    send_request(OP_LINKED, 8'd6, 7'd127, 7'd0);
    send_request(OP_REMOVE, 8'd0, 7'd0, 7'h7F);   // no start
    send_request(OP_REMOVE, 8'd0, 7'd0, 7'h40);   // most negative start
    send_request(OP_REMOVE, 8'd0, 7'd0, 7'd63);   // free block, nothing counted
    // whole disk in one file, then full-disk failures
    send_request(OP_CONTIG, 8'd255, 7'd64, 7'd0);
    send_request(OP_CONTIG, 8'd1, 7'd1, 7'd0);
    send_request(OP_LINKED, 8'd1, 7'd1, 7'd0);
    send_request(OP_REMOVE, 8'd0, 7'd0, 7'd0);
    // fragment the disk so first fit and linked claims skip holes
    send_request(OP_CONTIG, 8'd1, 7'd3, 7'd0);
    send_request(OP_LINKED, 8'd2, 7'd2, 7'd0);
    send_request(OP_CONTIG, 8'd3, 7'd5, 7'd0);
    send_request(OP_REMOVE, 8'd0, 7'd0, 7'd3);
    send_request(OP_CONTIG, 8'd4, 7'd3, 7'd0);
    send_request(OP_LINKED, 8'd7, 7'd4, 7'd0);
    send_request(OP_REMOVE, 8'd0, 7'd0, 7'd5);
    send_request(OP_LINKED, 8'd8, 7'd64, 7'd0);   // too few free
    send_request(OP_LINKED, 8'd9, 7'd54, 7'd0);   // exactly the free count
    send_request(OP_REMOVE, 8'd0, 7'd0, 7'd3);    // scattered chain
    send_request(OP_REMOVE, 8'd0, 7'd0, 7'd3);    // same start, now free
    send_request(OP_REMOVE, 8'd0, 7'd0, 7'd2);    // last block of a file

    // random: mostly allocate and remove known files, some noise
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      pick  = $urandom_range(0, 99);
      id    = ID_W'($urandom_range(0, 255));
      len   = LEN_W'($urandom_range(0, 127));
      start = FB_W'($urandom_range(0, 127));
      if (pick < 45 || (pick < 85 && tracker.file_heads.size() == 0)) begin
        op = $urandom_range(0, 1) ? OP_LINKED : OP_CONTIG;
        lsel = $urandom_range(0, 99);
        if (lsel < 3) len = '0;
        else if (lsel < 6) len = LEN_W'($urandom_range(65, 127));
        else if (lsel < 16) len = LEN_W'($urandom_range(1, 64));
        else len = LEN_W'($urandom_range(1, 8));
      end else if (pick < 85) begin
        op = OP_REMOVE;
        idx = $urandom_range(0, tracker.file_heads.size() - 1);
        start = tracker.file_heads[idx];
        tracker.file_heads.delete(idx);
      end else if (pick < 95) begin
        op = OP_REMOVE;
        start = FB_W'($urandom_range(0, NUM_BLOCKS - 1));
      end else begin
        op = OP_W'($urandom_range(0, 3));
      end
      send_request(op, id, len, start);
    end
    s_tvalid <= 1'b0;

    // drain outstanding results, then allow for a late extra one
    while (tracker.awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d results: %0d succeeded, %0d out of space or bad length, %0d not found",
             tracker.checked, tracker.status_tally[ST_OK], tracker.status_tally[ST_NOSPACE],
             tracker.status_tally[ST_NOTFOUND]);
    $display("requests mixed first-fit runs, scattered chains, chain removals and bad fields");
    if (tracker.errors == 0 && tracker.awaited_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/dab_pkg.sv
rtl/dab_ram.sv
rtl/dab_datapath.sv
rtl/dab_ctrl.sv
rtl/disk_block_allocator.sv
tb/disk_block_allocator_tb.sv
